@@ rtl/trct_pkg.sv @@
// Shared types and constants for the table row and column totals block.
`default_nettype none

package trct_pkg;

    // Field widths
    localparam int ELEM_W     = 32;
    localparam int SUM_W      = 48;
    localparam int IDX_W      = 6;
    localparam int KIND_W     = 2;
    localparam int ROWS_W     = 7;
    localparam int COLS_W     = 6;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 56;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ROW   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GRAND = 2'd2;

    // Register indexes (paddr[2])
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Register reset values
    localparam logic [ROWS_W-1:0] RESET_ROWS = 7'd5;
    localparam logic [COLS_W-1:0] RESET_COLS = 6'd6;

    // One result beat
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  idx;
        logic [SUM_W-1:0]  value;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/trct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module trct_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire                                   aclk,
    input  wire                                   wr_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]                      wr_data,
    input  wire                                   rd_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/table_row_column_totals.sv @@
// Top level: row, column and grand totals of a table streamed in row-major order.
//
//  channel   dir  beat holds
//  -------   ---  ------------------------------------------------------------
//  s_        in   one table element (s_tdata, signed 32 bit)
//  m_        out  one total: tuser kind, tdata index and 48-bit sum, tlast
//  apb       in   rows_in_use at 0x0, cols_in_use at 0x4
//
// Elements are taken one per cycle while the sequencer runs and the output
// register is free; an element that ends a row puts the row total into that
// register as it is accepted. Column sums live in a RAM with registered read,
// updated in the cycle after the element (read, add, write back, forwarding on
// back-to-back hits). At the end of a table input stalls: a settle state for
// the last column write, a read and an output state per column, and a grand
// total state; longer while m_tready is low. Reset is synchronous; per-column
// valid bits stand in for a cleared RAM, so no clearing pass is needed.
`default_nettype none

module table_row_column_totals import trct_pkg::*; #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 32
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    // element input
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire  [S_TDATA_W-1:0]    s_tdata,   // [31:0] element_value
    // totals output
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata,   // [5:0] sum_index, [53:6] sum_value, [55:54] 0
    output logic [KIND_W-1:0]       m_tuser,   // [1:0] sum_kind
    output logic                    m_tlast,   // last_of_run
    // configuration
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [CFG_ADDR_W-1:0]   paddr,
    input  wire  [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int RP_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int RCMP_W = (RCNT_W > ROWS_W) ? RCNT_W : ROWS_W;
    localparam int CP_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int CCMP_W = (CCNT_W > COLS_W) ? CCNT_W : COLS_W;

    // Sequencer states
    localparam logic [2:0] ST_RUN    = 3'd0;
    localparam logic [2:0] ST_SETTLE = 3'd1;
    localparam logic [2:0] ST_DRD    = 3'd2;
    localparam logic [2:0] ST_DWAIT  = 3'd3;
    localparam logic [2:0] ST_GRAND  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [ROWS_W-1:0]   rows_reg;
    logic [COLS_W-1:0]   cols_reg;
    logic [RCNT_W-1:0]   rows_eff;
    logic [CCNT_W-1:0]   cols_eff;

    logic [SUM_W-1:0]    row_acc_reg, row_acc_next;
    logic [SUM_W-1:0]    grand_reg, grand_next;
    logic [RP_W-1:0]     row_pos_reg, row_pos_next;
    logic [CP_W-1:0]     col_pos_reg, col_pos_next;
    logic [CP_W-1:0]     drain_col_reg, drain_col_next;
    logic [MAX_COLS-1:0] col_valid_reg, col_valid_next;

    // update stage behind the RAM read
    logic                p1_valid_reg;
    logic [CP_W-1:0]     p1_col_reg;
    logic [SUM_W-1:0]    p1_value_reg;
    logic                p1_fwd_reg, p1_fwd_next;
    logic [SUM_W-1:0]    p1_fwd_data_reg;
    logic                rd_vld_reg;

    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic                accept;
    logic                slot_free;
    logic [SUM_W-1:0]    elem_ext;
    logic [SUM_W-1:0]    row_sum;
    logic                row_end;
    logic                table_end;
    logic                rd_en;
    logic [CP_W-1:0]     rd_addr;
    logic [SUM_W-1:0]    rd_data;
    logic [SUM_W-1:0]    p1_base;
    logic [SUM_W-1:0]    p1_sum;
    logic [SUM_W-1:0]    drain_value;
    logic                cfg_write;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= RESET_ROWS;
            cols_reg <= RESET_COLS;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_ROWS: rows_reg <= pwdata[ROWS_W-1:0];
                REG_COLS: cols_reg <= pwdata[COLS_W-1:0];
                default:  rows_reg <= rows_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ROWS: prdata = CFG_DATA_W'(rows_reg);
            REG_COLS: prdata = CFG_DATA_W'(cols_reg);
            default:  prdata = '0;
        endcase
    end

    // Table size: zero counts as one, too large saturates
    always_comb begin
        if (rows_reg == '0) begin
            rows_eff = RCNT_W'(1);
        end else if (RCMP_W'(rows_reg) > RCMP_W'(MAX_ROWS)) begin
            rows_eff = RCNT_W'(MAX_ROWS);
        end else begin
            rows_eff = RCNT_W'(rows_reg);
        end
        if (cols_reg == '0) begin
            cols_eff = CCNT_W'(1);
        end else if (CCMP_W'(cols_reg) > CCMP_W'(MAX_COLS)) begin
            cols_eff = CCNT_W'(MAX_COLS);
        end else begin
            cols_eff = CCNT_W'(cols_reg);
        end
    end

    // Input side
    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_RUN) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign elem_ext  = {{(SUM_W - ELEM_W){s_tdata[ELEM_W-1]}}, s_tdata[ELEM_W-1:0]};
    assign row_sum   = row_acc_reg + elem_ext;
    assign row_end   = !((CCNT_W'(col_pos_reg) + CCNT_W'(1)) < cols_eff);
    assign table_end = (RCNT_W'(row_pos_reg) + RCNT_W'(1)) >= rows_eff;

    // Column sum RAM
    assign rd_en   = accept || (state_reg == ST_DRD);
    assign rd_addr = (state_reg == ST_DRD) ? drain_col_reg : col_pos_reg;

    trct_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_COLS)
    ) u_col_ram (
        .aclk    (aclk),
        .wr_en   (p1_valid_reg),
        .wr_addr (p1_col_reg),
        .wr_data (p1_sum),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Read-modify-write: forwarded sum beats the RAM on a same-column hit
    always_comb begin
        if (p1_fwd_reg) begin
            p1_base = p1_fwd_data_reg;
        end else if (rd_vld_reg) begin
            p1_base = rd_data;
        end else begin
            p1_base = '0;
        end
    end
    assign p1_sum      = p1_base + p1_value_reg;
    assign p1_fwd_next = p1_valid_reg && (p1_col_reg == col_pos_reg);
    assign drain_value = rd_vld_reg ? rd_data : '0;

    // Sequencer and accumulators
    always_comb begin
        state_next     = state_reg;
        row_acc_next   = row_acc_reg;
        grand_next     = grand_reg;
        row_pos_next   = row_pos_reg;
        col_pos_next   = col_pos_reg;
        drain_col_next = drain_col_reg;
        col_valid_next = col_valid_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (p1_valid_reg) begin
            col_valid_next[p1_col_reg] = 1'b1;
        end

        case (state_reg)
            ST_RUN: begin
                if (accept) begin
                    grand_next = grand_reg + elem_ext;
                    if (row_end) begin
                        out_next.kind  = KIND_ROW;
                        out_next.idx   = IDX_W'(row_pos_reg);
                        out_next.value = row_sum;
                        out_next.last  = !table_end;
                        out_valid_next = 1'b1;
                        row_acc_next   = '0;
                        col_pos_next   = '0;
                        if (table_end) begin
                            row_pos_next = '0;
                            state_next   = ST_SETTLE;
                        end else begin
                            row_pos_next = row_pos_reg + RP_W'(1);
                        end
                    end else begin
                        row_acc_next = row_sum;
                        col_pos_next = col_pos_reg + CP_W'(1);
                    end
                end
            end
            ST_SETTLE: begin
                // last column write lands this cycle
                state_next = ST_DRD;
            end
            ST_DRD: begin
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (slot_free) begin
                    out_next.kind  = KIND_COL;
                    out_next.idx   = IDX_W'(drain_col_reg);
                    out_next.value = drain_value;
                    out_next.last  = 1'b0;
                    out_valid_next = 1'b1;
                    col_valid_next[drain_col_reg] = 1'b0;
                    if ((CCNT_W'(drain_col_reg) + CCNT_W'(1)) >= cols_eff) begin
                        drain_col_next = '0;
                        state_next     = ST_GRAND;
                    end else begin
                        drain_col_next = drain_col_reg + CP_W'(1);
                        state_next     = ST_DRD;
                    end
                end
            end
            ST_GRAND: begin
                if (slot_free) begin
                    out_next.kind  = KIND_GRAND;
                    out_next.idx   = '0;
                    out_next.value = grand_reg;
                    out_next.last  = 1'b1;
                    out_valid_next = 1'b1;
                    grand_next     = '0;
                    // columns past a shrunken width are dropped as well
                    col_valid_next = '0;
                    state_next     = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            row_acc_reg   <= '0;
            grand_reg     <= '0;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            drain_col_reg <= '0;
            col_valid_reg <= '0;
            p1_valid_reg  <= 1'b0;
            p1_fwd_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_acc_reg   <= row_acc_next;
            grand_reg     <= grand_next;
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            drain_col_reg <= drain_col_next;
            col_valid_reg <= col_valid_next;
            p1_valid_reg  <= accept;
            p1_fwd_reg    <= accept && p1_fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (accept) begin
            p1_col_reg      <= col_pos_reg;
            p1_value_reg    <= elem_ext;
            p1_fwd_data_reg <= p1_sum;
        end
        if (rd_en) begin
            rd_vld_reg <= col_valid_reg[rd_addr];
        end
    end

    // Output beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - IDX_W - SUM_W){1'b0}}, out_reg.value, out_reg.idx};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    // Checks
    a_p1_only_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> (state_reg == ST_RUN || state_reg == ST_SETTLE))
        else $error("column update in flight during drain");

    a_drain_after_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRD) |-> !p1_valid_reg && !accept)
        else $error("drain read overlaps element traffic");

    a_grand_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_GRAND) |-> m_tlast)
        else $error("grand total beat without tlast");

    a_col_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_COL) |-> !m_tlast)
        else $error("column total beat with tlast");

endmodule

`default_nettype wire

@@ verif/table_row_column_totals_tb.sv @@
// Self-checking testbench for table_row_column_totals: streams tables and checks every total.
`timescale 1ns / 1ps

module table_row_column_totals_tb;
    import trct_pkg::*;

    localparam int TABLE_ROWS_MAX  = 64;
    localparam int TABLE_COLS_MAX  = 32;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 2 * TABLE_COLS_MAX + 16;
    localparam int STALL_LIMIT     = 4000;
    localparam int RANDOM_ELEMENTS = 40;
    localparam int REPORT_LIMIT    = 10;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata  = '0;   // [31:0] element_value
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;         // [5:0] sum_index, [53:6] sum_value, [55:54] 0
    logic [KIND_W-1:0]       m_tuser;         // [1:0] sum_kind
    logic                    m_tlast;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr    = '0;
    logic [CFG_DATA_W-1:0]   pwdata   = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    // Predictor state: sizes as written, running sums and table position
    logic [ROWS_W-1:0] rows_reg    = RESET_ROWS;
    logic [COLS_W-1:0] cols_reg    = RESET_COLS;
    logic [SUM_W-1:0]  row_total   = '0;
    logic [SUM_W-1:0]  grand_total = '0;
    logic [SUM_W-1:0]  col_totals [TABLE_COLS_MAX] = '{default: '0};
    int                row_pos     = 0;
    int                col_pos     = 0;
    bit                table_closed = 1'b0;

    result_t totals_due[$];
    bit      idling_on     = 1'b0;
    int      mismatches    = 0;
    int      elements_sent = 0;
    int      idle_cycles   = 0;
    int      stall_left    = 0;

    table_row_column_totals u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // Receiver: random stall bursts while idling is on
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 6);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic int effective_size(input int value, input int limit);
        if (value == 0) return 1;
        if (value > limit) return limit;
        return value;
    endfunction

    // Row total at each row end; column totals and grand total at table end
    task automatic predict_totals(input logic [ELEM_W-1:0] value);
        logic [SUM_W-1:0] widened;
        int               rows;
        int               cols;
        bit               table_end;
        rows    = effective_size(int'(rows_reg), TABLE_ROWS_MAX);
        cols    = effective_size(int'(cols_reg), TABLE_COLS_MAX);
        widened = {{(SUM_W - ELEM_W){value[ELEM_W-1]}}, value};
        row_total           += widened;
        grand_total         += widened;
        col_totals[col_pos] += widened;
        if (col_pos + 1 < cols) begin
            col_pos++;
            return;
        end
        // a position past a shrunk size also ends the row or table
        table_end = (row_pos + 1 >= rows);
        totals_due.push_back('{kind: KIND_ROW, idx: IDX_W'(row_pos), value: row_total,
                               last: !table_end});
        row_total = '0;
        col_pos   = 0;
        if (!table_end) begin
            row_pos++;
            return;
        end
        for (int c = 0; c < cols; c++)
            totals_due.push_back('{kind: KIND_COL, idx: IDX_W'(c), value: col_totals[c],
                                   last: 1'b0});
        totals_due.push_back('{kind: KIND_GRAND, idx: '0, value: grand_total, last: 1'b1});
        col_totals   = '{default: '0};
        grand_total  = '0;
        row_pos      = 0;
        table_closed = 1'b1;
    endtask

    task automatic report_total(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $write("%0t: %s: expected kind %0d index %0d sum %0d last %0b, ",
                   $time, what, want.kind, want.idx, $signed(want.value), want.last);
            $display("got kind %0d index %0d sum %0d last %0b",
                     got.kind, got.idx, $signed(got.value), got.last);
        end
    endtask

    // Result checker: each beat against the oldest expected total
    always @(posedge aclk) begin : total_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind  = m_tuser;
            got.idx   = m_tdata[IDX_W-1:0];
            got.value = m_tdata[IDX_W +: SUM_W];
            got.last  = m_tlast;
            if (totals_due.size() == 0) begin
                report_total("unexpected total", '0, got);
            end else begin
                want = totals_due.pop_front();
                if (got.kind !== want.kind || got.idx !== want.idx ||
                    got.value !== want.value || got.last !== want.last)
                    report_total("bad total", want, got);
            end
        end
    end

    // Watchdog on cycles without any accepted beat or register access
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One element beat; valid stays high until the caller stops sending or idles it
    task automatic send_element(input logic [ELEM_W-1:0] value);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tdata  <= value;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_totals(value);
        elements_sent++;
    endtask

    // Stop sending, wait for all totals, then let the column RAM settle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (totals_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic reg_sel, input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (reg_sel == REG_ROWS)
            rows_reg = data[ROWS_W-1:0];
        else
            cols_reg = data[COLS_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Upper data bits are random; only the register's own bits count
    task automatic set_table_size(input int rows, input int cols);
        logic [CFG_DATA_W-1:0] data;
        data             = $urandom;
        data[ROWS_W-1:0] = rows[ROWS_W-1:0];
        write_register(REG_ROWS, data);
        data             = $urandom;
        data[COLS_W-1:0] = cols[COLS_W-1:0];
        write_register(REG_COLS, data);
    endtask

    function automatic logic [ELEM_W-1:0] random_element();
        case ($urandom_range(0, 7))
            0:       return {1'b0, {(ELEM_W - 1){1'b1}}};
            1:       return {1'b1, {(ELEM_W - 1){1'b0}}};
            2:       return $urandom_range(0, 32) - 16;
            default: return $urandom;
        endcase
    endfunction

    // Random elements until the current table ends
    task automatic finish_table();
        table_closed = 1'b0;
        do
            send_element(random_element());
        while (!table_closed);
    endtask

    task automatic test_reset_sizes();
        idling_on = 1'b1;
        finish_table();
        settle();
    endtask

    task automatic test_value_extremes();
        set_table_size(2, 2);
        send_element(32'h7FFF_FFFF);
        send_element(32'h8000_0000);
        send_element(32'h0000_0000);
        send_element(32'hFFFF_FFFF);
        settle();
        set_table_size(1, 2);
        send_element(32'h5555_5555);
        send_element(32'hAAAA_AAAA);
        settle();
    endtask

    // Zero in a size register counts as one
    task automatic test_zero_sizes();
        set_table_size(0, 0);
        send_element(32'h8000_0000);
        send_element(32'h7FFF_FFFF);
        settle();
    endtask

    task automatic test_mid_table_resize();
        // shrink: position past the new last column and row closes the table
        set_table_size(3, 4);
        repeat (7) send_element(random_element());
        settle();
        set_table_size(1, 2);
        send_element(random_element());
        settle();
        // grow: the row runs on to the wider size
        set_table_size(2, 2);
        send_element(random_element());
        settle();
        set_table_size(2, 5);
        finish_table();
        settle();
    endtask

    // Sizes above the maximum saturate
    task automatic test_saturated_sizes();
        set_table_size(1, 63);
        finish_table();
        settle();
        set_table_size(127, 1);
        finish_table();
        settle();
    endtask

    task automatic test_random_tables();
        int target;
        int done;
        int rows;
        int cols;
        target = elements_sent + RANDOM_ELEMENTS;
        while (elements_sent < target) begin
            done      = RANDOM_ELEMENTS - (target - elements_sent);
            // quiet stretch in the middle, none at all near the end
            idling_on = (done < RANDOM_ELEMENTS / 3) ||
                        (done >= RANDOM_ELEMENTS / 2 && done < RANDOM_ELEMENTS * 3 / 4);
            rows = $urandom_range(0, 4);
            cols = $urandom_range(0, 7);
            if ($urandom_range(0, 15) == 0) begin
                rows = 1;
                cols = $urandom_range(33, 63);
            end
            set_table_size(rows, cols);
            if ($urandom_range(0, 4) == 0) begin
                // broken table: resized part way through
                table_closed = 1'b0;
                repeat ($urandom_range(1, 5))
                    if (!table_closed) send_element(random_element());
                settle();
                set_table_size($urandom_range(0, 4), $urandom_range(0, 7));
                if (!table_closed) finish_table();
            end else begin
                finish_table();
            end
            settle();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_sizes();
        test_value_extremes();
        test_zero_sizes();
        test_mid_table_resize();
        test_saturated_sizes();
        test_random_tables();
        idling_on = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
